FILE: src/ecgiir_pkg.sv
// ecgiir_pkg: shared types, codes and Q15 coefficients of the three-mode ECG filter.
// Used by ecg_iir_filter_three_mode_top and ecgiir_checker; depends on nothing.
`timescale 1ns / 1ps

package ecgiir_pkg;

  // filter mode codes
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_LP  = 2'd1;
  localparam logic [1:0] MODE_BP  = 2'd2;
  localparam logic [1:0] MODE_SEC = 2'd3;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  // datapath widths
  localparam int OPA_W  = 34;
  localparam int OPB_W  = 20;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 56;

  // last multiply step of each filter
  localparam logic [2:0] LAST_LP  = 3'd6;
  localparam logic [2:0] LAST_BP  = 3'd5;
  localparam logic [2:0] LAST_SEC = 3'd3;

  // Q15 coefficients
  localparam logic signed [OPB_W-1:0] LP_B   = 20'sd2709;
  localparam logic signed [OPB_W-1:0] LP_A0  = -20'sd594;
  localparam logic signed [OPB_W-1:0] LP_A1  = 20'sd1078;
  localparam logic signed [OPB_W-1:0] LP_A2  = -20'sd16178;
  localparam logic signed [OPB_W-1:0] LP_A3  = 20'sd5118;
  localparam logic signed [OPB_W-1:0] BP_B   = 20'sd8631;
  localparam logic signed [OPB_W-1:0] BP_A0  = -20'sd5723;
  localparam logic signed [OPB_W-1:0] BP_A1  = 20'sd15063;
  localparam logic signed [OPB_W-1:0] BP_A2  = -20'sd43319;
  localparam logic signed [OPB_W-1:0] BP_A3  = 20'sd66656;
  localparam logic signed [OPB_W-1:0] SEC_B  = 20'sd16569;
  localparam logic signed [OPB_W-1:0] SEC_A0 = -20'sd1854;
  localparam logic signed [OPB_W-1:0] SEC_A1 = 20'sd33026;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_DONE
  } state_e;

  // history of one second-order section
  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic signed [31:0] y1;
    logic signed [31:0] y2;
  } sec_hist_t;

endpackage

FILE: src/ecg_iir_filter_three_mode_top.sv
// Three-mode fixed-point ECG IIR filter: one shared multiplier under a step sequencer.
// Depends on ecgiir_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one raw 16-bit sample and an
//   end-of-block mark per request; output channel (out_valid_o/out_ready_i)
//   returns one filtered sample with the mark copied.
//   Configuration goes through an APB-style port: mode at 0x0, gain at 0x4,
//   offset at 0x8; pready is tied high. Write registers only while idle.
//   One multiplier is shared by all products; each product passes through a
//   multiply state and an accumulate state. The cascade runs its SECTIONS
//   sections in turn; mode zero skips the multiplier and goes straight to done.
//   After each item the sequencer goes back to idle before the next request.
//   in_ready_o is high only while the sequencer is idle. A finished result
//   sits in the output register; the next request is taken meanwhile, and
//   the sequencer waits at its end if that register is still occupied.
//   Reset clears all filter histories and loads mode 1, gain 1, offset 2047.
module ecg_iir_filter_three_mode_top
  import ecgiir_pkg::*;
#(
  parameter int SECTIONS   = 6,
  parameter int COEF_SHIFT = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_i,
  input  logic        end_of_block_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] filtered_o,
  output logic        end_of_block_out_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

  // configuration registers
  logic [1:0]  mode_q;
  logic [4:0]  gain_q;
  logic [15:0] offset_q;

  // sequencer and datapath
  state_e state_q, state_d;
  logic [2:0]              step_q;
  logic [SEC_W-1:0]        sec_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [OPB_W-1:0]  k_q;
  logic [15:0]             corr_q;
  logic [15:0]             x_q;
  logic                    eob_q;
  logic signed [31:0]      v_q;
  logic [15:0]             res_q;

  // histories
  logic [15:0]        px_q [4];
  logic signed [31:0] py_q [4];
  sec_hist_t          sh_q [SECTIONS];

  // output register
  logic        out_valid_q;
  logic [15:0] filtered_q;
  logic        eob_out_q;

  logic in_fire, out_free, cfg_wr;
  logic [2:0] last_step;
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  acc_shr;
  logic signed [31:0]       y_w;
  logic [15:0]              res_w;
  logic signed [OPA_W-1:0]  t_lp, t_bp, t_sec;
  logic [4:0]               sec_gain;

  // 4*(p2+p0) + 6*p1 + x, all unsigned and narrow
  function automatic logic [20:0] sample_hold_sum(logic [15:0] x, logic [15:0] p2,
                                                 logic [15:0] p0, logic [15:0] p1);
    logic [20:0] s;
    s = 21'(x) + (21'(p2) << 2) + (21'(p0) << 2) + (21'(p1) << 2) + (21'(p1) << 1);
    return s;
  endfunction

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LP;
      gain_q   <= 5'd1;
      offset_q <= 16'd2047;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MODE:   mode_q   <= pwdata[1:0];
        REG_GAIN:   gain_q   <= pwdata[4:0];
        REG_OFFSET: offset_q <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = {30'd0, mode_q};
      REG_GAIN:   prdata = {27'd0, gain_q};
      REG_OFFSET: prdata = {16'd0, offset_q};
      default:    prdata = 32'd0;
    endcase
  end

  // input terms of each filter
  assign t_lp = OPA_W'(px_q[3]) + OPA_W'(sample_hold_sum(x_q, px_q[2], px_q[0], px_q[1]));
  assign t_bp = OPA_W'(px_q[3]) + OPA_W'(x_q) - (OPA_W'(px_q[1]) <<< 1);
  assign t_sec = OPA_W'(v_q) - OPA_W'(sh_q[0].x2);
  assign sec_gain = (int'(sec_q) < 2) ? gain_q : 5'd1;

  always_comb begin
    unique case (mode_q)
      MODE_LP:  last_step = LAST_LP;
      MODE_BP:  last_step = LAST_BP;
      MODE_SEC: last_step = LAST_SEC;
      default:  last_step = LAST_SEC;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (mode_q == MODE_SEC) begin
      unique case (step_q)
        3'd0: begin op_a = OPA_W'(sec_gain); op_b = SEC_B;  end
        3'd1: begin op_a = t_sec;            op_b = k_q;    end
        3'd2: begin op_a = OPA_W'(sh_q[0].y2); op_b = SEC_A0; end
        3'd3: begin op_a = OPA_W'(sh_q[0].y1); op_b = SEC_A1; end
        default: ;
      endcase
    end else begin
      unique case (step_q)
        3'd0: begin
          op_a = OPA_W'(gain_q);
          op_b = (mode_q == MODE_LP) ? LP_B : BP_B;
        end
        3'd1: begin op_a = (mode_q == MODE_LP) ? t_lp : t_bp; op_b = k_q; end
        3'd2: begin op_a = OPA_W'(py_q[3]); op_b = (mode_q == MODE_LP) ? LP_A0 : BP_A0; end
        3'd3: begin op_a = OPA_W'(py_q[2]); op_b = (mode_q == MODE_LP) ? LP_A1 : BP_A1; end
        3'd4: begin op_a = OPA_W'(py_q[1]); op_b = (mode_q == MODE_LP) ? LP_A2 : BP_A2; end
        3'd5: begin op_a = OPA_W'(py_q[0]); op_b = (mode_q == MODE_LP) ? LP_A3 : BP_A3; end
        3'd6: begin op_a = OPA_W'(offset_q); op_b = OPB_W'(gain_q); end
        default: ;
      endcase
    end
  end

  assign mul_p = op_a * op_b;

  // scale down and wrap to 32 bits, then offset correction
  assign acc_shr = acc_q >>> COEF_SHIFT;
  assign y_w     = acc_shr[31:0];
  always_comb begin
    if (mode_q == MODE_LP) res_w = y_w[15:0] + offset_q - corr_q;
    else                   res_w = y_w[15:0] + offset_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = (mode_q == MODE_OFF) ? ST_DONE : ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = (step_q == last_step) ? ST_FIN : ST_MUL;
      ST_FIN:  state_d = (mode_q == MODE_SEC && sec_q != SEC_LAST) ? ST_MUL : ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o         = (state_q == ST_IDLE);
    out_valid_o        = out_valid_q;
    filtered_o         = filtered_q;
    end_of_block_out_o = eob_out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // sequencer counters and arithmetic registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      sec_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          sec_q  <= '0;
        end
        ST_ACC:  if (step_q != last_step) step_q <= step_q + 3'd1;
        ST_FIN: begin
          step_q <= '0;
          if (sec_q != SEC_LAST) sec_q <= sec_q + SEC_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          x_q   <= sample_i;
          eob_q <= end_of_block_i;
          v_q   <= 32'(signed'({1'b0, sample_i}));
          res_q <= 16'd0;
        end
      end
      ST_MUL: prod_q <= mul_p;
      ST_ACC: begin
        if (step_q == 3'd0)                           k_q    <= prod_q[OPB_W-1:0];
        else if (step_q == 3'd1)                      acc_q  <= ACC_W'(prod_q);
        else if (mode_q == MODE_LP && step_q == 3'd6) corr_q <= prod_q[15:0];
        else                                          acc_q  <= acc_q + ACC_W'(prod_q);
      end
      ST_FIN: begin
        v_q   <= y_w;
        res_q <= res_w;
      end
      default: ;
    endcase
  end

  // filter histories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        px_q[i] <= '0;
        py_q[i] <= '0;
      end
      for (int i = 0; i < SECTIONS; i++) sh_q[i] <= '0;
    end else if (state_q == ST_FIN) begin
      if (mode_q == MODE_SEC) begin
        // rotate: updated section goes to the back, next one comes to the front
        for (int i = 0; i < SECTIONS - 1; i++) sh_q[i] <= sh_q[i+1];
        sh_q[SECTIONS-1] <= '{x1: v_q, x2: sh_q[0].x1, y1: y_w, y2: sh_q[0].y1};
      end else begin
        px_q[3] <= px_q[2];
        px_q[2] <= px_q[1];
        px_q[1] <= px_q[0];
        px_q[0] <= x_q;
        py_q[3] <= py_q[2];
        py_q[2] <= py_q[1];
        py_q[1] <= py_q[0];
        py_q[0] <= y_w;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      filtered_q <= res_q;
      eob_out_q  <= eob_q;
    end
  end

endmodule

FILE: src/ecgiir_checker.sv
// ecgiir_props: port-level assertions for ecg_iir_filter_three_mode_top, with its bind.
// Depends on ecgiir_pkg and the top level's port list.
`timescale 1ns / 1ps

module ecgiir_props
  import ecgiir_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] filtered_o,
  input logic        end_of_block_out_o,
  input logic        pready
);

  // a taken request keeps the sequencer busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready_o high right after a request was taken");

  // no result can come out of the datapath in the cycle after a request
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after a request");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_o)
      && $stable(end_of_block_out_o))
    else $error("stalled result changed");

  // configuration port never stalls
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind ecg_iir_filter_three_mode_top ecgiir_props u_ecgiir_props (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .filtered_o         (filtered_o),
  .end_of_block_out_o (end_of_block_out_o),
  .pready             (pready)
);

FILE: verif/ecgiir_checker.sv
// ecgiir_checker: watches the sample, result and configuration ports of the ECG filter,
// predicts every filtered sample and compares it with what the block returns.
// Depends on ecgiir_pkg for mode codes, register indexes and Q15 coefficients.
`timescale 1ns / 1ps

module ecgiir_checker
  import ecgiir_pkg::*;
#(
  parameter int SECTIONS   = 6,
  parameter int COEF_SHIFT = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample channel
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] sample_i,
  input  logic        end_of_block_i,
  // result channel
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] filtered_i,
  input  logic        end_of_block_out_i,
  // configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  // status for the testbench top
  output int unsigned outstanding_o,
  output int unsigned fail_count_o
);

  typedef struct packed {
    logic [15:0] filtered;
    logic        eob;
  } filt_result_t;

  // shadow copy of the configuration registers
  logic [1:0]  cfg_mode;
  logic [4:0]  cfg_gain;
  logic [15:0] cfg_offset;

  // shadow filter histories, newest first
  longint lp_bp_in_hist[4];
  longint lp_bp_out_hist[4];
  longint sec_in_hist[2*SECTIONS];
  longint sec_out_hist[2*SECTIONS];

  filt_result_t predicted_outputs[$];
  filt_result_t want;
  int unsigned  mismatch_count;

  assign fail_count_o = mismatch_count;

  // keep the low 32 bits as a two's complement value
  function automatic longint wrap_word(input longint v);
    logic signed [31:0] w;
    w = v[31:0];
    return longint'(w);
  endfunction

  function automatic void shift_direct_hist(input longint x, input longint y);
    lp_bp_in_hist[3]  = lp_bp_in_hist[2];
    lp_bp_in_hist[2]  = lp_bp_in_hist[1];
    lp_bp_in_hist[1]  = lp_bp_in_hist[0];
    lp_bp_in_hist[0]  = x;
    lp_bp_out_hist[3] = lp_bp_out_hist[2];
    lp_bp_out_hist[2] = lp_bp_out_hist[1];
    lp_bp_out_hist[1] = lp_bp_out_hist[0];
    lp_bp_out_hist[0] = y;
  endfunction

  // one filter step: updates the shadow histories and returns the expected result
  function automatic filt_result_t filter_sample(input logic [15:0] smp, input logic eob);
    longint       x, g, off, acc, y, v, k, res;
    int           s;
    filt_result_t r;
    x   = smp;
    g   = cfg_gain;
    off = cfg_offset;
    res = 0;
    case (cfg_mode)
      MODE_LP: begin
        acc = g * LP_B * ((lp_bp_in_hist[3] + x) + 4 * (lp_bp_in_hist[2] + lp_bp_in_hist[0])
                          + 6 * lp_bp_in_hist[1])
            + LP_A0 * lp_bp_out_hist[3] + LP_A1 * lp_bp_out_hist[2]
            + LP_A2 * lp_bp_out_hist[1] + LP_A3 * lp_bp_out_hist[0];
        y = wrap_word(acc >>> COEF_SHIFT);
        shift_direct_hist(x, y);
        res = y - off * (g - 1);
      end
      MODE_BP: begin
        acc = g * BP_B * ((lp_bp_in_hist[3] + x) - 2 * lp_bp_in_hist[1])
            + BP_A0 * lp_bp_out_hist[3] + BP_A1 * lp_bp_out_hist[2]
            + BP_A2 * lp_bp_out_hist[1] + BP_A3 * lp_bp_out_hist[0];
        y = wrap_word(acc >>> COEF_SHIFT);
        shift_direct_hist(x, y);
        res = y + off;
      end
      MODE_SEC: begin
        // gain applies to the first two sections only
        v = x;
        for (s = 0; s < SECTIONS; s++) begin
          k   = (s < 2) ? g : 1;
          acc = k * SEC_B * (v - sec_in_hist[2*s+1])
              + SEC_A0 * sec_out_hist[2*s+1] + SEC_A1 * sec_out_hist[2*s];
          y = wrap_word(acc >>> COEF_SHIFT);
          sec_in_hist[2*s+1]  = sec_in_hist[2*s];
          sec_in_hist[2*s]    = v;
          sec_out_hist[2*s+1] = sec_out_hist[2*s];
          sec_out_hist[2*s]   = y;
          v = y;
        end
        res = v + off;
      end
      default: begin
        // mode zero: nothing runs, output is zero
        res = 0;
      end
    endcase
    r.filtered = res[15:0];
    r.eob      = eob;
    return r;
  endfunction

  // compare results, predict new requests, track register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode       = MODE_LP;
      cfg_gain       = 5'd1;
      cfg_offset     = 16'd2047;
      lp_bp_in_hist  = '{default: 0};
      lp_bp_out_hist = '{default: 0};
      sec_in_hist    = '{default: 0};
      sec_out_hist   = '{default: 0};
      predicted_outputs.delete();
      mismatch_count = 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_outputs.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result filtered=%h eob=%b", $time,
                   filtered_i, end_of_block_out_i);
        end else begin
          want = predicted_outputs.pop_front();
          if (want.filtered !== filtered_i || want.eob !== end_of_block_out_i) begin
            mismatch_count++;
            $display("%0t: mismatch expected filtered=%h eob=%b, actual filtered=%h eob=%b",
                     $time, want.filtered, want.eob, filtered_i, end_of_block_out_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        predicted_outputs.push_back(filter_sample(sample_i, end_of_block_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_MODE:   cfg_mode   = pwdata_i[1:0];
          REG_GAIN:   cfg_gain   = pwdata_i[4:0];
          REG_OFFSET: cfg_offset = pwdata_i[15:0];
          default:    ; // unmapped index, write dropped
        endcase
      end
      outstanding_o <= predicted_outputs.size();
    end
  end

endmodule

FILE: verif/tb.sv
// tb: drives samples and register writes into the three-mode ECG filter and gives the verdict.
// Depends on ecgiir_pkg, ecg_iir_filter_three_mode_top and ecgiir_checker.
`timescale 1ns / 1ps

module tb;
  import ecgiir_pkg::*;

  localparam int SECTIONS    = 6;
  localparam int COEF_SHIFT  = 15;
  localparam int NUM_PHASES  = 16;
  localparam int PHASE_ITEMS = 83;
  // index past the register map, writes there are dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [15:0] sample_i       = '0;
  logic        end_of_block_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [15:0] filtered_o;
  logic        end_of_block_out_o;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [3:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned outstanding;
  int unsigned fail_count;
  logic        hold_off_req = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  ecg_iir_filter_three_mode_top #(
    .SECTIONS   (SECTIONS),
    .COEF_SHIFT (COEF_SHIFT)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .sample_i           (sample_i),
    .end_of_block_i     (end_of_block_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .filtered_o         (filtered_o),
    .end_of_block_out_o (end_of_block_out_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  ecgiir_checker #(
    .SECTIONS   (SECTIONS),
    .COEF_SHIFT (COEF_SHIFT)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .sample_i           (sample_i),
    .end_of_block_i     (end_of_block_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .filtered_i         (filtered_o),
    .end_of_block_out_i (end_of_block_out_o),
    .psel_i             (psel),
    .penable_i          (penable),
    .pwrite_i           (pwrite),
    .paddr_i            (paddr),
    .pwdata_i           (pwdata),
    .pready_i           (pready),
    .outstanding_o      (outstanding),
    .fail_count_o       (fail_count)
  );

  // one request on the sample channel; returns at the accepting edge
  task automatic send_sample(input logic [15:0] smp, input logic eob);
    in_valid_i     <= 1'b1;
    sample_i       <= smp;
    end_of_block_i <= eob;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    // let the sequencer get back to idle
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup phase, then access phase, then idle with psel low
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side: stall patterns, plus a long hold-off when asked
  initial begin : rx_stall
    int          run_len;
    int          style;
    logic        hold_done;
    hold_done = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ((hold_off_req && !hold_done) || $urandom_range(0, 29) == 0) begin
        hold_done = hold_off_req;
        out_ready_i <= 1'b0;
        repeat ($urandom_range(250, 400)) @(posedge clk_i);
      end else begin
        style   = $urandom_range(0, 3);
        run_len = $urandom_range(10, 150);
        repeat (run_len) begin
          case (style)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= 1'($urandom_range(0, 1));
            2:       out_ready_i <= ($urandom_range(0, 7) != 0);
            default: out_ready_i <= ($urandom_range(0, 7) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // sample side: directed cases, then randomized configuration phases
  initial begin : stimulus
    int          ph;
    int          n;
    int          burst_left;
    logic [15:0] smp;
    logic [1:0]  mode;
    logic [4:0]  gain;
    logic [15:0] offset;
    logic [31:0] junk;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset defaults: lowpass, gain 1, offset 2047
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0001, 1'b0);
    wait_drained();

    // bandpass at full gain, zero offset
    reg_write(REG_MODE, 32'(MODE_BP));
    reg_write(REG_GAIN, 32'd16);
    reg_write(REG_OFFSET, 32'd0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    wait_drained();

    // cascade with gain above the usual range and top offset
    reg_write(REG_MODE, 32'(MODE_SEC));
    reg_write(REG_GAIN, 32'd31);
    reg_write(REG_OFFSET, 32'hFFFF);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h5555, 1'b1);
    wait_drained();

    // mode zero: output zero, histories untouched
    reg_write(REG_MODE, 32'(MODE_OFF));
    send_sample(16'h1234, 1'b1);
    send_sample(16'hAAAA, 1'b0);
    wait_drained();

    // zero gain in lowpass turns the offset correction into an addition
    reg_write(REG_MODE, 32'(MODE_LP));
    reg_write(REG_GAIN, 32'd0);
    reg_write(REG_OFFSET, 32'd1000);
    send_sample(16'h2000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    wait_drained();

    // write to an unmapped index must not disturb anything
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_sample(16'h0800, 1'b0);
    wait_drained();

    // random phases
    burst_left = 0;
    smp        = 16'd2047;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      if (ph == 2) hold_off_req <= 1'b1;

      mode = 2'(MODE_LP + ph % 3);
      if ($urandom_range(0, 11) == 0) mode = MODE_OFF;
      case ($urandom_range(0, 9))
        0, 1:    gain = 5'd1;
        2, 3:    gain = 5'd16;
        4:       gain = $urandom_range(0, 1) ? 5'd0 : 5'd31;
        default: gain = 5'($urandom_range(1, 16));
      endcase
      if (ph == 0) gain = 5'd1;
      if (ph == 1) gain = 5'd16;
      case ($urandom_range(0, 5))
        0:       offset = 16'd0;
        1:       offset = 16'hFFFF;
        2:       offset = 16'd2047;
        default: offset = 16'($urandom);
      endcase
      // upper bits of the write data are don't-care
      junk = $urandom;
      reg_write(REG_MODE, {junk[31:2], mode});
      junk = $urandom;
      reg_write(REG_GAIN, {junk[31:5], gain});
      junk = $urandom;
      reg_write(REG_OFFSET, {junk[31:16], offset});

      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) begin
            in_valid_i <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk_i);
          end
        end
        // occasional full drain in the middle of a phase
        if ($urandom_range(0, 49) == 0) wait_drained();
        case ($urandom_range(0, 9))
          0, 1, 2: smp = 16'($urandom);
          3, 4, 5: smp = 16'(32'd2047 + $urandom_range(0, 600) - 32'd300);
          6:       smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          7:       smp = smp + 16'($urandom_range(0, 15)) - 16'd7;
          default: ; // repeat the last sample, steady input
        endcase
        send_sample(smp, 1'($urandom_range(0, 1)));
        burst_left--;
      end
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // about 1400 requests, result stalls included, several times over
  initial begin : watchdog
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
